// ===== design/md5_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 package
// Step constants, rotation amounts and the initial vector of the MD5 core.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  function automatic word_t sine_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// ===== design/md5_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 channel interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        end_of_message;
  modport source (output valid, data_word, valid_bytes, end_of_message, input ready);
  modport sink   (input valid, data_word, valid_bytes, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/md5_digest_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine
// Gathers message bytes into 16-word blocks, compresses, pads, emits digest.
// ----------------------------------------------------------------------------
// A beat is accepted in IDLE, its valid bytes are packed in FEED, and a
// closing FEED cycle moves on to IDLE, or to PAD after the final beat. A
// beat that fills a block runs the 64 compression steps in COMP (one step
// per cycle in one shared step unit) and then folds into the chaining value
// in FOLD. In PAD the final beat feeds padding and length one byte per
// cycle, pausing for each compression (up to two more), and then offers
// four digest beats. No new beat is accepted until the last one is done.
// Synchronous active-low reset returns the initial vector.
module md5_digest_engine
  import md5_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FEED = 6'b000010,
    S_COMP = 6'b000100,
    S_FOLD = 6'b001000,
    S_PAD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  word_t       cv_r [4];
  word_t       wr_r [4];
  word_t       blk_r [16];
  logic [3:0]  fill_r;
  word_t       part_r;
  logic [1:0]  pbytes_r;
  logic [63:0] len_r;
  logic [5:0]  step_r;
  word_t       data_r;
  logic [2:0]  cnt_r;     // bytes of the held beat still to pack
  logic [1:0]  bsel_r;
  logic        last_r;
  logic [3:0]  pad_r;     // 0: 0x80, 1: zeros, 2..9: length bytes
  logic [1:0]  oidx_r;
  logic [7:0]  byte_v;
  logic        push;
  logic [3:0]  g;
  word_t       b_new;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.digest_word = cv_r[oidx_r];
  assign out_ch.word_index = oidx_r;
  assign out_ch.last_word = (oidx_r == 2'd3);

  always_comb begin
    case (step_r[5:4])
      2'd0: g = step_r[3:0];
      2'd1: g = 4'(5 * step_r[3:0] + 1);
      2'd2: g = 4'(3 * step_r[3:0] + 5);
      default: g = 4'(7 * step_r[3:0]);
    endcase
  end

  md5_round u_round (
    .step(step_r), .a(wr_r[0]), .b(wr_r[1]), .c(wr_r[2]), .d(wr_r[3]),
    .m(blk_r[g]), .b_new(b_new)
  );

  // Next byte of the byte stream in FEED or PAD. The length counter holds
  // still during padding, so the length bytes come straight from it.
  always_comb begin
    byte_v = 8'h00;
    push = 1'b0;
    if (state_r == S_FEED && cnt_r != 3'd0) begin
      byte_v = data_r[8*bsel_r +: 8];
      push = 1'b1;
    end else if (state_r == S_PAD) begin
      push = 1'b1;
      if (pad_r == 4'd0) byte_v = PAD_BYTE;
      else if (pad_r >= 4'd2) byte_v = len_r[8*(pad_r - 4'd2) +: 8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_FEED;
      S_FEED: if (push && pbytes_r == 2'd3 && fill_r == 4'd15) state_nxt = S_COMP;
              else if (cnt_r == 3'd0) state_nxt = last_r ? S_PAD : S_IDLE;
      S_COMP: if (step_r == 6'd63) state_nxt = S_FOLD;
      S_FOLD: state_nxt = (cnt_r != 3'd0) ? S_FEED :
                          (!last_r) ? S_IDLE : (pad_r == 4'd10) ? S_OUT : S_PAD;
      S_PAD: begin
        if (pbytes_r == 2'd3 && fill_r == 4'd15) state_nxt = S_COMP;
        else if (pad_r == 4'd9) state_nxt = S_OUT;
      end
      S_OUT: if (out_ch.ready && oidx_r == 2'd3) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cv_r[0] <= IV_A; cv_r[1] <= IV_B; cv_r[2] <= IV_C; cv_r[3] <= IV_D;
      fill_r <= '0; part_r <= '0; pbytes_r <= '0; len_r <= '0;
      step_r <= '0; cnt_r <= '0; last_r <= 1'b0; pad_r <= '0; oidx_r <= '0;
      bsel_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          data_r <= in_ch.data_word;
          cnt_r <= (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
          bsel_r <= '0;
          last_r <= in_ch.end_of_message;
          pad_r <= '0;
        end
        S_FEED: begin
          if (cnt_r != 3'd0) begin
            cnt_r <= cnt_r - 3'd1;
            bsel_r <= bsel_r + 2'd1;
            len_r <= len_r + 64'd8;
          end
        end
        S_PAD: begin
          // The 0x80 byte may itself reach 56 bytes, leaving no zero bytes.
          if (pad_r == 4'd0) pad_r <= (fill_r == 4'd13 && pbytes_r == 2'd3) ? 4'd2 : 4'd1;
          else if (pad_r == 4'd1) begin
            if (fill_r == 4'd13 && pbytes_r == 2'd3) pad_r <= 4'd2;
          end else pad_r <= pad_r + 4'd1;
        end
        S_COMP: begin
          wr_r[0] <= wr_r[3]; wr_r[3] <= wr_r[2]; wr_r[2] <= wr_r[1];
          wr_r[1] <= b_new;
          step_r <= step_r + 6'd1;
        end
        S_FOLD: begin
          for (int i = 0; i < 4; i++) cv_r[i] <= cv_r[i] + wr_r[i];
          step_r <= '0;
          if (pad_r == 4'd10) pad_r <= 4'd10;
        end
        S_OUT: if (out_ch.ready) begin
          oidx_r <= oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            cv_r[0] <= IV_A; cv_r[1] <= IV_B; cv_r[2] <= IV_C; cv_r[3] <= IV_D;
            fill_r <= '0; part_r <= '0; pbytes_r <= '0; len_r <= '0;
            last_r <= 1'b0; pad_r <= '0;
          end
        end
        default: ;
      endcase
      if (push) begin
        if (pbytes_r == 2'd3) begin
          blk_r[fill_r] <= part_r | {byte_v, 24'h0};
          part_r <= '0;
          fill_r <= fill_r + 4'd1;
          if (fill_r == 4'd15) begin
            for (int i = 0; i < 4; i++) wr_r[i] <= cv_r[i];
          end
        end else begin
          part_r <= part_r | (word_t'(byte_v) << (8 * pbytes_r));
        end
        pbytes_r <= pbytes_r + 2'd1;
      end
    end
  end
endmodule

// ===== design/md5_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 step unit
// One compression step: round function, four-way add, rotate, add b.
// ----------------------------------------------------------------------------
module md5_round
  import md5_pkg::*;
(
  input  logic [5:0] step,
  input  word_t      a,
  input  word_t      b,
  input  word_t      c,
  input  word_t      d,
  input  word_t      m,
  output word_t      b_new
);
  word_t      f;
  word_t      sum;
  word_t      rot;
  logic [4:0] s;

  always_comb begin
    case (step[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    s   = rot_s(step);
    sum = a + f + sine_k(step) + m;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    b_new = b + rot;
  end
endmodule

// ===== design/md5_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 port checker
// Port-level properties of the digest engine, bound into the digest engine.
// ----------------------------------------------------------------------------
module md5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_word_index,
  input logic        out_last_word
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while digest pending");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 2'd3)))
    else $error("last_word mismatch");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_word_index != 2'd3) |=>
    (out_valid && out_word_index == $past(out_word_index) + 2'd1))
    else $error("digest beat order broken");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
endmodule

bind md5_digest_engine md5_checker u_md5_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_word_index(out_ch.word_index), .out_last_word(out_ch.last_word)
);

// ===== dv/md5_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 testbench channel note
// The channel interfaces come from the design folder; this file only holds
// the shared type of one expected digest beat used by the testbench.
// ----------------------------------------------------------------------------
package md5_tb_pkg;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_beat_t;

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine testbench
// Sends messages as beats of up to four bytes, keeps its own MD5 model to
// predict the four digest beats of each message, and checks every digest
// beat in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import md5_pkg::*;
  import md5_tb_pkg::*;

  logic clk;
  logic rst_n;
  bit   failed;

  md5_in_if  msg_ch ();
  md5_out_if dig_ch ();

  md5_digest_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (msg_ch.sink),
    .out_ch (dig_ch.source)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Digest model: its own copy of the chaining value, block and length.
  // ---------------------------------------------------------------------
  logic [31:0] hash_state [4];
  logic [31:0] msg_words [16];
  int unsigned words_filled;
  logic [31:0] byte_accum;
  int unsigned bytes_in_accum;
  logic [63:0] msg_bits;
  digest_beat_t digest_queue [$];

  localparam logic [31:0] STEP_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int STEP_ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                   6, 10, 15, 21};

  function automatic void restart_hash();
    hash_state[0] = IV_A;
    hash_state[1] = IV_B;
    hash_state[2] = IV_C;
    hash_state[3] = IV_D;
    words_filled   = 0;
    byte_accum     = '0;
    bytes_in_accum = 0;
    msg_bits       = '0;
  endfunction

  function automatic void compress_words();
    logic [31:0] a, b, c, d, f, sum;
    int rnd, g;
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    for (int s = 0; s < 64; s++) begin
      rnd = s / 16;
      case (rnd)
        0: begin f = (b & c) | (~b & d); g = s; end
        1: begin f = (b & d) | (c & ~d); g = 5 * s + 1; end
        2: begin f = b ^ c ^ d; g = 3 * s + 5; end
        default: begin f = c ^ (b | ~d); g = 7 * s; end
      endcase
      sum = a + f + STEP_K[s] + msg_words[g % 16];
      a = d; d = c; c = b;
      b = b + ((sum << STEP_ROT[rnd * 4 + s % 4]) | (sum >> (32 - STEP_ROT[rnd * 4 + s % 4])));
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
  endfunction

  function automatic void absorb_byte(input logic [7:0] byte_val);
    byte_accum |= 32'(byte_val) << (8 * bytes_in_accum);
    bytes_in_accum++;
    if (bytes_in_accum == 4) begin
      msg_words[words_filled] = byte_accum;
      byte_accum = '0;
      bytes_in_accum = 0;
      words_filled++;
      if (words_filled == 16) begin
        compress_words();
        words_filled = 0;
      end
    end
  endfunction

  // Folds one accepted beat into the model; at the end of a message it pads,
  // appends the bit length and queues the four digest beats.
  function automatic void predict_digest(input logic [31:0] data, input logic [2:0] nbytes,
                                         input logic eom);
    int cnt;
    logic [63:0] len;
    digest_beat_t beat;
    cnt = (nbytes > 4) ? 4 : nbytes;
    for (int i = 0; i < cnt; i++) begin
      absorb_byte(data[8*i +: 8]);
      msg_bits += 64'd8;
    end
    if (eom) begin
      len = msg_bits;
      absorb_byte(PAD_BYTE);
      while (words_filled * 4 + bytes_in_accum != 56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[8*i +: 8]);
      for (int i = 0; i < 4; i++) begin
        beat.digest_word = hash_state[i];
        beat.word_index  = 2'(i);
        beat.last_word   = (i == 3);
        digest_queue.insert(digest_queue.size(), beat);
      end
      restart_hash();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one beat per call, with bursts and random gaps between them.
  // Valid stays high from one beat to the next inside a burst.
  // ---------------------------------------------------------------------
  int burst_left;
  int max_gap = 6;

  task automatic send_beat(input logic [31:0] data, input logic [2:0] nbytes,
                           input logic eom);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        msg_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    msg_ch.valid          <= 1'b1;
    msg_ch.data_word      <= data;
    msg_ch.valid_bytes    <= nbytes;
    msg_ch.end_of_message <= eom;
    do @(posedge clk); while (!msg_ch.ready);
    predict_digest(data, nbytes, eom);
    @(negedge clk);
  endtask

  // A message of the given byte length, full beats then one final beat of up to four bytes.
  task automatic send_message(input int nbytes);
    int left;
    int chunk;
    left = nbytes;
    while (left > 4) begin
      send_beat($urandom, 3'd4, 1'b0);
      left -= 4;
    end
    chunk = left;
    send_beat($urandom, 3'(chunk), 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stalls on its own pattern, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  int  stall_mode;
  int  hold_cycles;

  always @(negedge clk) begin
    if (!rst_n) begin
      dig_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      dig_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: dig_ch.ready <= 1'b1;
        1: dig_ch.ready <= ($urandom_range(0, 3) != 0);
        default: dig_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Checks every accepted digest beat against the oldest prediction.
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && dig_ch.valid && dig_ch.ready) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest beat, actual %h/%0d/%0b", $realtime,
                 dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
        failed = 1'b1;
      end else begin
        want = digest_queue.pop_front();
        if (dig_ch.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $realtime,
                   want.digest_word, dig_ch.digest_word);
          failed = 1'b1;
        end
        if (dig_ch.word_index !== want.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $realtime,
                   want.word_index, dig_ch.word_index);
          failed = 1'b1;
        end
        if (dig_ch.last_word !== want.last_word) begin
          $display("%0t: last_word expected %0b actual %0b", $realtime,
                   want.last_word, dig_ch.last_word);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Empty message, extreme data values, every valid-byte count including the
  // counts above four, a short beat in mid message and ignored upper lanes.
  task automatic test_directed();
    send_beat(32'h0, 3'd0, 1'b1);
    send_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
    send_beat(32'h0000_0000, 3'd4, 1'b1);
    for (int n = 1; n <= 7; n++) send_beat(32'hA5C3_7E19, 3'(n), 1'b1);
    send_beat(32'hFFFF_FF61, 3'd1, 1'b0);
    send_beat(32'hDEAD_6362, 3'd2, 1'b0);
    send_beat(32'h0000_0000, 3'd0, 1'b0);
    send_beat(32'hFFFF_FFFF, 3'd7, 1'b0);
    send_beat(32'h1234_5678, 3'd3, 1'b1);
    // 55 and 56 bytes straddle the point where padding needs a second block.
    send_message(55);
    send_message(56);
    send_message(64);
  endtask

  // Random messages, mostly short, a few of several blocks, with noisy beats.
  task automatic test_random_messages(input int beats);
    int sent;
    int len;
    sent = 0;
    while (sent < beats) begin
      stall_mode = $urandom_range(0, 2);
      max_gap    = ($urandom_range(0, 4) == 0) ? 0 : 6;
      if ($urandom_range(0, 9) == 0) begin
        // Ragged message: any count on any beat.
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          send_beat($urandom, 3'($urandom_range(0, 7)), i == len - 1);
        sent += len;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 40);
        send_message(len);
        sent += (len + 3) / 4 + 1;
      end
    end
  endtask

  // Receiver holds off for a long time while messages keep arriving.
  task automatic test_backpressure();
    stall_mode  = 0;
    max_gap     = 0;
    hold_cycles = 1500;
    for (int i = 0; i < 6; i++) send_message($urandom_range(1, 20));
  endtask

  initial begin
    rst_n = 1'b0;
    failed = 1'b0;
    burst_left = 0;
    stall_mode = 0;
    hold_cycles = 0;
    msg_ch.valid = 1'b0;
    msg_ch.data_word = '0;
    msg_ch.valid_bytes = '0;
    msg_ch.end_of_message = 1'b0;
    dig_ch.ready = 1'b0;
    restart_hash();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_messages(390);
    msg_ch.valid <= 1'b0;
    while (digest_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Generous bound on the whole run.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
